// ----- rtl/fcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants for the filled-circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  // Largest radius handled; larger requests saturate to it
  localparam int MAX_RADIUS      = 31;
  // Framebuffer geometry used for the byte offset of a span
  localparam int LINE_PIXELS     = 1024;
  localparam int BYTES_PER_PIXEL = 4;
  // Default number of commands buffered between front and back
  localparam int QUEUE_DEPTH     = 2;

  // One circle command
  typedef struct packed {
    logic [9:0] cx;
    logic [9:0] cy;
    logic [4:0] r;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

endpackage

// ----- rtl/fcsg_front.sv -----
// ----------------------------------------------------------------------------
// fcsg_front
// Accepts circle requests, saturates the radius and pushes the command
// into the queue in front of the span sequencer.
// ----------------------------------------------------------------------------
module fcsg_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [9:0]      centre_x,
  input  logic [9:0]      centre_y,
  input  logic [4:0]      radius,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  input  logic            q_full,
  output logic            q_push,
  output fcsg_pkg::cmd_t  q_cmd
);

  logic [4:0] r_sat;

  // Saturate the radius to the largest supported value
  assign r_sat = (radius > 5'(fcsg_pkg::MAX_RADIUS)) ? 5'(fcsg_pkg::MAX_RADIUS) : radius;

  // Take a request whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Pack the command
  always_comb begin
    q_cmd.cx    = centre_x;
    q_cmd.cy    = centre_y;
    q_cmd.r     = r_sat;
    q_cmd.red   = red;
    q_cmd.green = green;
    q_cmd.blue  = blue;
  end

endmodule

// ----- rtl/fcsg_queue.sv -----
// ----------------------------------------------------------------------------
// fcsg_queue
// Small command FIFO that decouples request intake from span generation.
// ----------------------------------------------------------------------------
module fcsg_queue #(
  parameter int DEPTH = fcsg_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fcsg_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output fcsg_pkg::cmd_t  pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fcsg_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fcsg_back.sv -----
// ----------------------------------------------------------------------------
// fcsg_back
// Span sequencer: walks the height from the radius down to zero, grows the
// half-width one step a cycle until it covers the circle, and emits the lower
// and upper span of each height through an output register.
// ----------------------------------------------------------------------------
module fcsg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  fcsg_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [10:0]  span_row,
  output logic signed [11:0]  span_left,
  output logic signed [11:0]  span_right,
  output logic signed [22:0]  start_offset,
  output logic [7:0]          byte_zero,
  output logic [7:0]          byte_one,
  output logic [7:0]          byte_two,
  output logic                last_span
);

  localparam logic [22:0] ROW_STRIDE =
    23'(fcsg_pkg::LINE_PIXELS * fcsg_pkg::BYTES_PER_PIXEL);
  localparam logic [22:0] PIX_STRIDE = 23'(fcsg_pkg::BYTES_PER_PIXEL);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT_LO,
    ST_EMIT_HI
  } state_t;

  state_t         state;
  fcsg_pkg::cmd_t cmd;
  logic [4:0]     h;
  logic [4:0]     d;
  logic [9:0]     dsq;
  logic [9:0]     need;

  logic           slot_free;
  logic           load;
  logic [10:0]    row_sel;
  logic [11:0]    left_sel;
  logic [11:0]    right_sel;
  logic [22:0]    row_ext;
  logic [22:0]    left_ext;
  logic [22:0]    ofs_sel;
  logic           out_valid_next;

  assign slot_free = !out_valid || out_ready;
  assign q_pop     = (state == ST_IDLE) && q_not_empty;
  assign load      = slot_free && ((state == ST_EMIT_LO) || (state == ST_EMIT_HI));

  // Span geometry for the row being emitted
  always_comb begin
    if (state == ST_EMIT_LO) begin
      row_sel = 11'(cmd.cy) + 11'(h);
    end else begin
      row_sel = 11'(cmd.cy) - 11'(h);
    end
    left_sel  = 12'(cmd.cx) - 12'(d);
    right_sel = 12'(cmd.cx) + 12'(d);
    row_ext   = {{12{row_sel[10]}}, row_sel};
    left_ext  = {{11{left_sel[11]}}, left_sel};
    ofs_sel   = 23'(row_ext * ROW_STRIDE) + 23'(left_ext * PIX_STRIDE);
  end

  assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  // Sequencer state, search registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      // Load the output payload when the slot frees up
      if (load) begin
        span_row     <= row_sel;
        span_left    <= left_sel;
        span_right   <= right_sel;
        start_offset <= ofs_sel;
        byte_zero    <= cmd.red;
        byte_one     <= cmd.green;
        byte_two     <= cmd.blue;
        last_span    <= (state == ST_EMIT_HI) && (h == '0);
      end
      case (state)
        ST_IDLE: begin
          if (q_not_empty) begin
            cmd   <= q_cmd;
            h     <= q_cmd.r;
            d     <= '0;
            dsq   <= '0;
            need  <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // Grow the half-width until its square covers r*r - h*h
          if (dsq < need) begin
            d   <= d + 1'b1;
            dsq <= dsq + 10'({d, 1'b1});
          end else begin
            state <= ST_EMIT_LO;
          end
        end
        ST_EMIT_LO: begin
          if (slot_free) begin
            state <= ST_EMIT_HI;
          end
        end
        ST_EMIT_HI: begin
          if (slot_free) begin
            if (h == '0) begin
              state <= ST_IDLE;
            end else begin
              // r*r - (h-1)^2 = r*r - h*h + 2h - 1
              h     <= h - 1'b1;
              need  <= need + 10'({h, 1'b0}) - 10'd1;
              state <= ST_SEARCH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Square register tracks the half-width while a command is active
  a_dsq_track: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (dsq == 10'(d) * 10'(d)))
    else $error("half-width square out of step");

  // Half-width at emit is the smallest that covers the row
  a_min_width: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LO) |->
      (dsq >= need) && ((d == '0) || (10'(dsq + 10'd1 - 10'({d, 1'b0})) < need)))
    else $error("half-width not minimal");

  // Half-width never exceeds the radius
  a_d_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (d <= cmd.r))
    else $error("half-width beyond radius");

  // Final upper span closes the command
  a_last_close: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_HI && slot_free && h == '0) |=>
      (state == ST_IDLE && out_valid && last_span))
    else $error("command not closed with last span");
`endif

endmodule

// ----- rtl/filled_circle_span_generator_core.sv -----
// A command's first span passes the queue, the sequencer's command load, the
//   half-width search and the output register. Radius r gives 2*(r+1) spans:
//   the back sequencer takes one half-width search step per cycle, then emits
//   the lower and upper span of each height, one per cycle while out_ready allows.
// Up to QUEUE_DEPTH further requests are taken while a command is in progress.
// Reset (rst, synchronous) empties the queue, idles the sequencer, drops out_valid.
// ----------------------------------------------------------------------------
// filled_circle_span_generator_core
// Turns filled-circle requests into horizontal spans with framebuffer offsets.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_core #(
  parameter int QUEUE_DEPTH = fcsg_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          centre_x,
  input  logic [9:0]          centre_y,
  input  logic [4:0]          radius,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [10:0]  span_row,
  output logic signed [11:0]  span_left,
  output logic signed [11:0]  span_right,
  output logic signed [22:0]  start_offset,
  output logic [7:0]          byte_zero,
  output logic [7:0]          byte_one,
  output logic [7:0]          byte_two,
  output logic                last_span
);

  fcsg_pkg::cmd_t push_cmd;
  fcsg_pkg::cmd_t pop_cmd;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_not_empty;

  // Intake and radius saturation
  fcsg_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .centre_x (centre_x),
    .centre_y (centre_y),
    .radius   (radius),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // Command queue
  fcsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  // Span sequencer
  fcsg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .span_row     (span_row),
    .span_left    (span_left),
    .span_right   (span_right),
    .start_offset (start_offset),
    .byte_zero    (byte_zero),
    .byte_one     (byte_one),
    .byte_two     (byte_two),
    .last_span    (last_span)
  );

endmodule
